// File: hw/rtl/edsr_pkg.sv
`default_nettype none

package edsr_pkg;

    localparam int BYTE_W  = 8;
    localparam int COORD_W = 6;

    localparam logic [COORD_W-1:0] COORD_RESET = 6'd32;

    // end-of-frame notice from the parser to the emitter
    typedef struct packed {
        logic fire;
        logic ok;
    } t_fin;

endpackage

`default_nettype wire

// File: hw/rtl/edsr_cfg_if.sv
`default_nettype none

interface edsr_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [edsr_pkg::COORD_W-1:0] coord_len;

    modport source (output valid, output coord_len, input ready);
    modport sink (input valid, input coord_len, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/edsr_in_if.sv
`default_nettype none

interface edsr_in_if;
    logic                        valid;
    logic                        ready;
    logic [edsr_pkg::BYTE_W-1:0] in_byte;
    logic                        in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/edsr_out_if.sv
`default_nettype none

interface edsr_out_if;
    logic                        valid;
    logic                        ready;
    logic [edsr_pkg::BYTE_W-1:0] out_byte;
    logic                        status;
    logic                        out_last;

    modport source (output valid, output out_byte, output status, output out_last,
                    input ready);
    modport sink (input valid, input out_byte, input status, input out_last,
                  output ready);
endinterface

`default_nettype wire

// File: hw/rtl/edsr_ram.sv
`default_nettype none

module edsr_ram #(
    parameter int W  = 8,
    parameter int D  = 64,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hw/rtl/edsr_parse.sv
`default_nettype none

module edsr_parse #(
    parameter int MAX_COORD = 32,
    localparam int AW = $clog2(2 * MAX_COORD)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    edsr_in_if.sink                           i_in,
    input  wire logic                         i_busy,
    input  wire logic [edsr_pkg::COORD_W-1:0] i_coord,
    output logic                              o_wr_en,
    output logic      [AW-1:0]                o_wr_addr,
    output logic      [edsr_pkg::BYTE_W-1:0]  o_wr_data,
    output edsr_pkg::t_fin                    o_fin
);

    localparam logic [3:0] PH_SEQ_TAG  = 4'd0;
    localparam logic [3:0] PH_SEQ_LEN  = 4'd1;
    localparam logic [3:0] PH_SEQ_SKIP = 4'd2;
    localparam logic [3:0] PH_R_TAG    = 4'd3;
    localparam logic [3:0] PH_R_LEN    = 4'd4;
    localparam logic [3:0] PH_R_LENX   = 4'd5;
    localparam logic [3:0] PH_R_BODY   = 4'd6;
    localparam logic [3:0] PH_S_TAG    = 4'd7;
    localparam logic [3:0] PH_S_LEN    = 4'd8;
    localparam logic [3:0] PH_S_LENX   = 4'd9;
    localparam logic [3:0] PH_S_BODY   = 4'd10;
    localparam logic [3:0] PH_DONE     = 4'd11;

    localparam logic [7:0] TAG_SEQ    = 8'h30;
    localparam logic [7:0] TAG_INT    = 8'h02;
    localparam logic [3:0] MIN_FRAME  = 4'd8;

    logic [3:0]  r_phase, n_phase;
    logic [3:0]  r_cnt, n_cnt;
    logic [31:0] r_len, n_len;
    logic [6:0]  r_left, n_left;
    logic [31:0] r_idx, n_idx;
    logic        r_strip, n_strip;
    logic        r_err, n_err;

    logic        accept;
    logic [7:0]  in_b;
    logic [31:0] coord32;
    logic        body_first, body_strip, body_skip, body_wr;
    logic [31:0] body_j, body_eff, idx_inc, lenx_val;
    logic [5:0]  body_off;
    logic [6:0]  body_pos;
    logic [6:0]  left_dec;
    logic        go_begin, is_r;

    assign accept   = i_in.valid && i_in.ready;
    assign i_in.ready = !i_busy;
    assign in_b     = i_in.in_byte;
    assign coord32  = {26'd0, i_coord};

    // the first content byte decides whether the leading zero is really dropped
    assign body_first = (r_idx == 32'd0);
    assign body_strip = r_strip && !(body_first && (in_b != 8'h00));
    assign body_skip  = body_first && body_strip;
    assign body_j     = r_idx - {31'd0, body_strip};
    assign body_eff   = r_len - {31'd0, body_strip};
    assign body_off   = (body_eff < coord32) ? (i_coord - body_eff[5:0]) : 6'd0;
    assign body_pos   = ((r_phase == PH_S_BODY) ? {1'b0, i_coord} : 7'd0)
                      + {1'b0, body_off} + {1'b0, body_j[5:0]};
    assign body_wr    = !body_skip && (body_j < coord32);
    assign idx_inc    = r_idx + 32'd1;
    assign lenx_val   = (r_len > 32'h00FF_FFFF) ? 32'hFFFF_FFFF : {r_len[23:0], in_b};
    assign left_dec   = r_left - 7'd1;
    assign is_r       = (r_phase == PH_R_LEN) || (r_phase == PH_R_LENX);

    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_len    = r_len;
        n_left   = r_left;
        n_idx    = r_idx;
        n_strip  = r_strip;
        n_err    = r_err;
        go_begin = 1'b0;
        o_wr_en  = 1'b0;
        o_fin    = '0;
        if (accept) begin
            if (r_cnt != MIN_FRAME) begin
                n_cnt = r_cnt + 4'd1;
            end
            if (!r_err) begin
                case (r_phase)
                    PH_SEQ_TAG: begin
                        if (in_b != TAG_SEQ) n_err = 1'b1;
                        else n_phase = PH_SEQ_LEN;
                    end
                    PH_SEQ_LEN: begin
                        if (in_b[7] && (in_b[6:0] != 7'd0)) begin
                            n_left  = in_b[6:0];
                            n_phase = PH_SEQ_SKIP;
                        end else begin
                            n_phase = PH_R_TAG;
                        end
                    end
                    PH_SEQ_SKIP: begin
                        n_left = left_dec;
                        if (left_dec == 7'd0) n_phase = PH_R_TAG;
                    end
                    PH_R_TAG, PH_S_TAG: begin
                        if (in_b != TAG_INT) n_err = 1'b1;
                        else n_phase = (r_phase == PH_R_TAG) ? PH_R_LEN : PH_S_LEN;
                    end
                    PH_R_LEN, PH_S_LEN: begin
                        if (!in_b[7]) begin
                            n_len    = {24'd0, in_b};
                            go_begin = 1'b1;
                        end else begin
                            n_len = 32'd0;
                            if (in_b[6:0] == 7'd0) begin
                                go_begin = 1'b1;
                            end else begin
                                n_left  = in_b[6:0];
                                n_phase = (r_phase == PH_R_LEN) ? PH_R_LENX : PH_S_LENX;
                            end
                        end
                    end
                    PH_R_LENX, PH_S_LENX: begin
                        n_len  = lenx_val;
                        n_left = left_dec;
                        if (left_dec == 7'd0) go_begin = 1'b1;
                    end
                    PH_R_BODY, PH_S_BODY: begin
                        n_strip = body_strip;
                        o_wr_en = body_wr;
                        n_idx   = idx_inc;
                        if (idx_inc == r_len) begin
                            n_phase = (r_phase == PH_R_BODY) ? PH_S_TAG : PH_DONE;
                        end
                    end
                    default: ;
                endcase
                if (go_begin) begin
                    if (n_len == 32'd0) begin
                        n_phase = is_r ? PH_S_TAG : PH_DONE;
                    end else begin
                        n_idx   = 32'd0;
                        n_strip = (n_len == coord32 + 32'd1);
                        n_phase = is_r ? PH_R_BODY : PH_S_BODY;
                    end
                end
            end
            if (i_in.in_last) begin
                o_fin.fire = 1'b1;
                o_fin.ok   = !n_err && (n_cnt == MIN_FRAME) && (n_phase == PH_DONE);
                n_phase = PH_SEQ_TAG;
                n_cnt   = 4'd0;
                n_len   = 32'd0;
                n_left  = 7'd0;
                n_idx   = 32'd0;
                n_strip = 1'b0;
                n_err   = 1'b0;
            end
        end
    end

    assign o_wr_addr = body_pos[AW-1:0];
    assign o_wr_data = in_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEQ_TAG;
            r_cnt   <= 4'd0;
            r_len   <= 32'd0;
            r_left  <= 7'd0;
            r_idx   <= 32'd0;
            r_strip <= 1'b0;
            r_err   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_len   <= n_len;
            r_left  <= n_left;
            r_idx   <= n_idx;
            r_strip <= n_strip;
            r_err   <= n_err;
        end
    end

`ifndef SYNTHESIS
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_fin.fire |=> (r_phase == PH_SEQ_TAG) && (r_cnt == 4'd0) && !r_err)
        else $error("parser state not cleared after frame end");
    a_store_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> (body_pos < {i_coord, 1'b0})
                    && ((r_phase == PH_R_BODY) || (r_phase == PH_S_BODY)))
        else $error("store write outside the raw r||s area");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/edsr_emit.sv
`default_nettype none

module edsr_emit #(
    parameter int MAX_COORD = 32,
    localparam int AW = $clog2(2 * MAX_COORD),
    localparam int D  = 2 * MAX_COORD
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire edsr_pkg::t_fin               i_fin,
    input  wire logic                         i_wr_en,
    input  wire logic [AW-1:0]                i_wr_addr,
    input  wire logic [edsr_pkg::COORD_W-1:0] i_coord,
    input  wire logic [edsr_pkg::BYTE_W-1:0]  i_rdata,
    output logic                              o_re,
    output logic      [AW-1:0]                o_raddr,
    output logic                              o_busy,
    edsr_out_if.source                        o_out
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EMIT = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    logic [1:0]    r_state;
    logic [AW-1:0] r_k;
    logic          r_pend;
    logic          r_rd_vld;
    logic          r_rd_last;
    logic [D-1:0]  r_vld;
    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_out_status;
    logic          r_out_last;

    logic          out_free;
    logic          issue;
    logic          err_load;
    logic [6:0]    total_m1;
    logic          k_is_last;
    logic          vld_clr;

    assign out_free  = !r_out_valid || o_out.ready;
    assign issue     = (r_state == ST_EMIT) && !r_pend && out_free;
    assign err_load  = (r_state == ST_ERR) && !r_pend && out_free;
    assign total_m1  = {i_coord, 1'b0} - 7'd1;
    assign k_is_last = (7'(r_k) == total_m1);
    // store is emptied after a bad frame ends or after the last read of a good one
    assign vld_clr   = ((r_state == ST_IDLE) && i_fin.fire && !i_fin.ok)
                     || (issue && k_is_last);

    assign o_re    = issue;
    assign o_raddr = r_k;
    assign o_busy  = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k         <= '0;
            r_pend      <= 1'b0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (vld_clr) begin
                r_vld <= '0;
            end else if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_fin.fire) begin
                        r_k <= '0;
                        if (i_fin.ok) begin
                            r_state <= ST_EMIT;
                        end else begin
                            r_state <= ST_ERR;
                        end
                    end
                end
                ST_EMIT: begin
                    if (issue) begin
                        if (k_is_last) begin
                            r_state <= ST_IDLE;
                            r_k     <= '0;
                        end else begin
                            r_k <= r_k + AW'(1);
                        end
                    end
                end
                ST_ERR: begin
                    if (err_load) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
            r_pend <= issue;
            if (r_pend || err_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // entries not written this frame read as zero
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_vld  <= r_vld[r_k];
            r_rd_last <= k_is_last;
        end
        if (r_pend) begin
            r_out_byte   <= r_rd_vld ? i_rdata : 8'h00;
            r_out_status <= 1'b0;
            r_out_last   <= r_rd_last;
        end else if (err_load) begin
            r_out_byte   <= 8'h00;
            r_out_status <= 1'b1;
            r_out_last   <= 1'b1;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.status   = r_out_status;
    assign o_out.out_last = r_out_last;

`ifndef SYNTHESIS
    a_land_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !r_out_valid)
        else $error("read data lands on an occupied output register");
    a_no_fire_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !i_fin.fire)
        else $error("frame end while a result burst is in progress");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/ecdsa_der_signature_to_raw.sv
`default_nettype none

// channel   dir   handshake      payload
// i_cfg     in    valid/ready    coord_len[5:0]
// i_in      in    valid/ready    in_byte[7:0], in_last
// o_out     out   valid/ready    out_byte[7:0], status, out_last
//
// One cycle per input byte while parsing; bytes go straight into the r||s RAM.
// After the last byte: 2*coord_len results (RAM read, output register; one at a
// time) or one error item; i_in and i_cfg stall until the last read is issued or the
// error item loaded. Entry valid bits clear the store at a bad frame's end or a good
// frame's last read, so no clearing pass is needed. Reset is synchronous, active low;
// coord_len resets to 32. o_out stalls hold the output register and pause RAM reads.
module ecdsa_der_signature_to_raw #(
    parameter int MAX_COORD = 32
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    edsr_cfg_if.sink     i_cfg,
    edsr_in_if.sink      i_in,
    edsr_out_if.source   o_out
);

    localparam int AW = $clog2(2 * MAX_COORD);

    logic [edsr_pkg::COORD_W-1:0] r_coord_size;
    logic [edsr_pkg::COORD_W-1:0] coord_eff;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [edsr_pkg::BYTE_W-1:0]  wr_data;
    logic                         re;
    logic [AW-1:0]                raddr;
    logic [edsr_pkg::BYTE_W-1:0]  rdata;
    logic                         busy;
    edsr_pkg::t_fin               fin;

    // the burst length depends on the setting, so hold writes off during a burst
    assign i_cfg.ready = !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coord_size <= edsr_pkg::COORD_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_coord_size <= i_cfg.coord_len;
        end
    end

    // zero acts as one, anything above the store size as the maximum
    assign coord_eff = (r_coord_size == '0) ? edsr_pkg::COORD_W'(1) :
                       (r_coord_size > edsr_pkg::COORD_W'(MAX_COORD)) ?
                       edsr_pkg::COORD_W'(MAX_COORD) : r_coord_size;

    edsr_parse #(.MAX_COORD(MAX_COORD)) u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_busy    (busy),
        .i_coord   (coord_eff),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_fin     (fin)
    );

    edsr_ram #(.W(edsr_pkg::BYTE_W), .D(2 * MAX_COORD)) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    edsr_emit #(.MAX_COORD(MAX_COORD)) u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fin     (fin),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_coord   (coord_eff),
        .i_rdata   (rdata),
        .o_re      (re),
        .o_raddr   (raddr),
        .o_busy    (busy),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire
